// ----- sv/gdds_pkg.sv -----
// shared types, constants and lookup functions for the gregorian date day shifter
`timescale 1ns / 1ps
`default_nettype none
package gdds_pkg;

   // field widths
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int OFFSET_W = 24;
   localparam int JD_W     = 23;

   // month codes
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // fallback date for a bad input
   localparam logic [MONTH_W-1:0] DEF_MONTH = MONTH_MAY;
   localparam logic [DAY_W-1:0]   DEF_DAY   = 5'd11;
   localparam logic [YEAR_W-1:0]  DEF_YEAR  = 14'd1959;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

   // julian day span of years 0 to 9999
   localparam logic [JD_W-1:0] JD_MIN = 23'd1721060;
   localparam logic [JD_W-1:0] JD_MAX = 23'd5373484;

   // reciprocal multipliers, exact for the stated dividend widths
   // floor(x / 100) for x below 2**14
   localparam int DIV100_SHIFT = 21;
   localparam logic [14:0] DIV100_MULT =
      15'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
   // floor(x / 146097) for x below 2**25
   localparam int CYCLE_SHIFT = 43;
   localparam logic [25:0] CYCLE_MULT =
      26'(((64'd1 << CYCLE_SHIFT) + 64'd146096) / 64'd146097);
   // floor(x / 1461001) for x below 2**28
   localparam int QUAD_SHIFT = 49;
   localparam logic [28:0] QUAD_MULT =
      29'(((64'd1 << QUAD_SHIFT) + 64'd1461000) / 64'd1461001);
   // floor(80 * x / 2447), folded into one constant
   localparam int MON_SHIFT = 27;
   localparam logic [22:0] MON_MULT =
      23'(64'd80 * (((64'd1 << MON_SHIFT) + 64'd2446) / 64'd2447));
   // floor(2447 * x / 80), folded into one constant
   localparam int DOM_SHIFT = 22;
   localparam logic [26:0] DOM_MULT =
      27'(64'd2447 * (((64'd1 << DOM_SHIFT) + 64'd79) / 64'd80));

   // checked date on its way to the shift stage
   typedef struct packed {
      logic [JD_W-1:0]            jd;
      logic signed [OFFSET_W-1:0] offset;
      logic                       bad;
   } jd_item_type;

   // one finished result
   typedef struct packed {
      logic [JD_W-1:0]    julian_day;
      logic [MONTH_W-1:0] new_month;
      logic [DAY_W-1:0]   new_day;
      logic [YEAR_W-1:0]  new_year;
      logic               was_invalid;
      logic               out_of_range;
   } result_type;

   // last day of a month, zero for a code that is no month
   function automatic logic [DAY_W-1:0] last_day(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
      logic [DAY_W-1:0] d;
      unique case (m) inside
         MONTH_FEB: begin
            d = leap ? 5'd29 : 5'd28;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            d = 5'd30;
         end
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT,
         MONTH_DEC: begin
            d = 5'd31;
         end
         default: begin
            d = 5'd0;
         end
      endcase
      return d;
   endfunction

   // floor(367 * shifted month / 12), march based
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] t;
      unique case (m)
         MONTH_JAN: t = 9'd336;
         MONTH_FEB: t = 9'd367;
         MONTH_MAR: t = 9'd30;
         MONTH_APR: t = 9'd61;
         MONTH_MAY: t = 9'd91;
         MONTH_JUN: t = 9'd122;
         MONTH_JUL: t = 9'd152;
         MONTH_AUG: t = 9'd183;
         MONTH_SEP: t = 9'd214;
         MONTH_OCT: t = 9'd244;
         MONTH_NOV: t = 9'd275;
         MONTH_DEC: t = 9'd305;
         default:   t = 9'd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// ----- sv/gregorian_date_day_shifter_top.sv -----
// top level of the gregorian date day shifter
//
// Takes a month, day, year and a signed day offset per item and returns one
// result per item: the julian day number of the checked input date and the
// shifted date as month, day and year. A bad month, a bad day, a day past
// the month end, february 29 outside a leap year (4/100/400 rule) or a year
// above 9999 is replaced by may 11, 1959 and flagged with was_invalid. A
// shifted date before january 1 of year 0 or after december 31 of year 9999
// is clamped to that end and flagged with out_of_range. The datapath is a
// 13 stage pipeline (4 stages for the check and forward conversion, 9 for
// the offset add, clamp and inverse conversion), and a new item can be taken
// every cycle as long as the result side takes its results.
// Each stage holds at most two multipliers, all by constants; all divisions
// are by constants and are done as reciprocal multiplies, shifts or compares.
// Every stage carries its own valid bit and holds while it is full and the
// stage after it cannot move on, so a stall on the result side fills the
// bubbles first and only then pushes back on req_ready. There is no state
// beyond the pipeline; reset only clears the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_day_shifter_top import gdds_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input item channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MONTH_W-1:0]         req_month_in,
   input  logic [DAY_W-1:0]           req_day_in,
   input  logic [YEAR_W-1:0]          req_year_in,
   input  logic signed [OFFSET_W-1:0] req_offset_days,
   // result item channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [JD_W-1:0]            rsp_julian_day,
   output logic [MONTH_W-1:0]         rsp_new_month,
   output logic [DAY_W-1:0]           rsp_new_day,
   output logic [YEAR_W-1:0]          rsp_new_year,
   output logic                       rsp_was_invalid,
   output logic                       rsp_out_of_range
);

   // handoff between the forward and inverse halves
   logic        mid_valid;
   logic        mid_ready;
   jd_item_type mid_item;
   result_type  res;

   // date check, fallback date and julian day number
   gdds_to_jd u_to_jd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .month     (req_month_in),
      .day       (req_day_in),
      .year      (req_year_in),
      .offset    (req_offset_days),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // offset add, clamp and conversion back to a calendar date;
   // its last stage is the result register seen on the rsp ports
   gdds_from_jd u_from_jd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (res)
   );

   assign rsp_julian_day   = res.julian_day;
   assign rsp_new_month    = res.new_month;
   assign rsp_new_day      = res.new_day;
   assign rsp_new_year     = res.new_year;
   assign rsp_was_invalid  = res.was_invalid;
   assign rsp_out_of_range = res.out_of_range;

endmodule
`default_nettype wire

// ----- sv/gdds_to_jd.sv -----
// date check and forward julian day conversion, four pipeline stages
`timescale 1ns / 1ps
`default_nettype none
module gdds_to_jd import gdds_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [MONTH_W-1:0]         month,
   input  logic [DAY_W-1:0]           day,
   input  logic [YEAR_W-1:0]          year,
   input  logic signed [OFFSET_W-1:0] offset,
   output logic                       out_valid,
   input  logic                       out_ready,
   output jd_item_type                out_item
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] vld_ff, vld_in, adv;

   // stage 0: year / 100
   logic [28:0]                ydiv_prod;
   logic [7:0]                 ydiv_in, ydiv_ff;
   logic [MONTH_W-1:0]         month_s0_ff;
   logic [DAY_W-1:0]           day_s0_ff;
   logic [YEAR_W-1:0]          year_s0_ff;
   logic signed [OFFSET_W-1:0] off_s0_ff;

   // stage 1: check and fallback
   logic [YEAR_W-1:0]          hund;
   logic                       rem_zero, leap, date_ok, early;
   logic [MONTH_W-1:0]         vm;
   logic [DAY_W-1:0]           vd;
   logic [YEAR_W-1:0]          vy;
   logic [YEAR_W-1:0]          x1_in, x1_ff, x3_in, x3_ff;
   logic [8:0]                 t2_s1_ff;
   logic [DAY_W-1:0]           day_s1_ff;
   logic                       bad_s1_ff;
   logic signed [OFFSET_W-1:0] off_s1_ff;

   // stage 2: products
   logic [24:0]                t1_prod;
   logic [28:0]                q3_prod;
   logic [JD_W-1:0]            t1_in, t1_ff;
   logic [7:0]                 q3_in, q3_ff;
   logic [8:0]                 t2_s2_ff;
   logic [DAY_W-1:0]           day_s2_ff;
   logic                       bad_s2_ff;
   logic signed [OFFSET_W-1:0] off_s2_ff;

   // stage 3: sum
   logic [9:0]                 t3_x3;
   logic [23:0]                jd_sum;
   jd_item_type                item_in, item_ff;

   // stall control
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_item  = item_ff;

   // stage 0
   always_comb begin
      ydiv_prod = {15'd0, year} * {14'd0, DIV100_MULT};
      ydiv_in   = ydiv_prod[DIV100_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ydiv_ff     <= ydiv_in;
         month_s0_ff <= month;
         day_s0_ff   <= day;
         year_s0_ff  <= year;
         off_s0_ff   <= offset;
      end
   end

   // stage 1: 4/100/400 rule from the quotient and its remainder
   always_comb begin
      hund     = {6'd0, ydiv_ff} * 14'd100;
      rem_zero = (year_s0_ff == hund);
      leap     = ((year_s0_ff[1:0] == 2'd0) && !rem_zero) ||
                 (rem_zero && (ydiv_ff[1:0] == 2'd0));
      date_ok  = (year_s0_ff <= YEAR_MAX) && (month_s0_ff >= MONTH_JAN) &&
                 (month_s0_ff <= MONTH_DEC) && (day_s0_ff != '0) &&
                 (day_s0_ff <= last_day(month_s0_ff, leap));
      vm       = date_ok ? month_s0_ff : DEF_MONTH;
      vd       = date_ok ? day_s0_ff   : DEF_DAY;
      vy       = date_ok ? year_s0_ff  : DEF_YEAR;
      // january and february count as months of the previous year
      early    = (vm <= MONTH_FEB);
      x1_in    = vy + 14'd4800 - {13'd0, early};
      x3_in    = vy + 14'd4900 - {13'd0, early};
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         x1_ff     <= x1_in;
         x3_ff     <= x3_in;
         t2_s1_ff  <= month_offset(vm);
         day_s1_ff <= vd;
         bad_s1_ff <= !date_ok;
         off_s1_ff <= off_s0_ff;
      end
   end

   // stage 2
   always_comb begin
      t1_prod = {11'd0, x1_ff} * 25'd1461;
      t1_in   = t1_prod[24:2];
      q3_prod = {15'd0, x3_ff} * {14'd0, DIV100_MULT};
      q3_in   = q3_prod[DIV100_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         t1_ff     <= t1_in;
         q3_ff     <= q3_in;
         t2_s2_ff  <= t2_s1_ff;
         day_s2_ff <= day_s1_ff;
         bad_s2_ff <= bad_s1_ff;
         off_s2_ff <= off_s1_ff;
      end
   end

   // stage 3
   always_comb begin
      t3_x3          = {2'd0, q3_ff} + {1'b0, q3_ff, 1'b0};
      jd_sum         = {1'b0, t1_ff} + 24'(t2_s2_ff) + 24'(day_s2_ff)
                       - 24'(t3_x3[9:2]) - 24'd32075;
      item_in.jd     = jd_sum[JD_W-1:0];
      item_in.offset = off_s2_ff;
      item_in.bad    = bad_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/gdds_from_jd.sv -----
// offset add, clamp and inverse julian day conversion, nine pipeline stages
`timescale 1ns / 1ps
`default_nettype none
module gdds_from_jd import gdds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  jd_item_type in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_res
);

   localparam int STAGES = 9;

   typedef struct packed {
      logic [JD_W-1:0] jd;
      logic            bad;
      logic            clamp;
   } tag_type;

   logic [STAGES-1:0] vld_ff, vld_in, adv;
   tag_type           tag_in;
   tag_type           tag_ff [STAGES];

   // stage 0
   logic signed [24:0] sh_sum;
   logic               lo, hi;
   logic [JD_W-1:0]    sh_in, sh_ff;
   // stage 1
   logic [JD_W-1:0]    l_in, l_ff;
   logic [50:0]        n_prod;
   logic [7:0]         n_in, n_s1_ff, n_s2_ff, n_s3_ff, n_s4_ff;
   // stage 2
   logic [24:0]        p_prod, p_bias;
   logic [JD_W-1:0]    l2_diff;
   logic [15:0]        l2_in, l2_s2_ff, l2_s3_ff, l2_s4_ff;
   // stage 3
   logic [27:0]        x2_in, x2_ff;
   // stage 4
   logic [56:0]        i_prod;
   logic [6:0]         i_in, i_ff;
   // stage 5
   logic [17:0]        t_prod, l3_sum;
   logic [15:0]        yb_in, yb_s5_ff, yb_s6_ff, yb_s7_ff;
   logic [8:0]         l3_in, l3_s5_ff, l3_s6_ff;
   // stage 6
   logic [31:0]        j_prod;
   logic [3:0]         j_in, j_s6_ff, j_s7_ff;
   // stage 7
   logic [30:0]        k_prod;
   logic [8:0]         k_diff;
   logic [DAY_W-1:0]   day_in, day_s7_ff, day_ff;
   // stage 8
   logic               lq;
   logic [15:0]        year_sum;
   logic [MONTH_W-1:0] mon_in, mon_ff;
   logic [YEAR_W-1:0]  year_in, year_ff;

   // stall control
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];

   // stage 0: add offset and clamp to the year 0 to 9999 span
   always_comb begin
      sh_sum = $signed({2'b00, in_item.jd}) +
               $signed({in_item.offset[OFFSET_W-1], in_item.offset});
      lo     = sh_sum < $signed({2'b00, JD_MIN});
      hi     = sh_sum > $signed({2'b00, JD_MAX});
      if (lo) begin
         sh_in = JD_MIN;
      end else if (hi) begin
         sh_in = JD_MAX;
      end else begin
         sh_in = sh_sum[JD_W-1:0];
      end
      tag_in.jd    = in_item.jd;
      tag_in.bad   = in_item.bad;
      tag_in.clamp = lo || hi;
   end

   // side data rides along with each stage
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tag_ff[0] <= tag_in;
         sh_ff     <= sh_in;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (adv[k]) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // stage 1: century count
   always_comb begin
      l_in   = sh_ff + 23'd68569;
      n_prod = {26'd0, l_in, 2'b00} * {25'd0, CYCLE_MULT};
      n_in   = n_prod[CYCLE_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         l_ff    <= l_in;
         n_s1_ff <= n_in;
      end
   end

   // stage 2: day within the century
   always_comb begin
      p_prod  = {17'd0, n_s1_ff} * 25'd146097;
      p_bias  = p_prod + 25'd3;
      l2_diff = l_ff - p_bias[24:2];
      l2_in   = l2_diff[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         l2_s2_ff <= l2_in;
         n_s2_ff  <= n_s1_ff;
      end
   end

   // stage 3
   assign x2_in = ({12'd0, l2_s2_ff} + 28'd1) * 28'd4000;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         x2_ff    <= x2_in;
         l2_s3_ff <= l2_s2_ff;
         n_s3_ff  <= n_s2_ff;
      end
   end

   // stage 4: year within the century
   always_comb begin
      i_prod = {29'd0, x2_ff} * {28'd0, QUAD_MULT};
      i_in   = i_prod[QUAD_SHIFT +: 7];
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         i_ff     <= i_in;
         l2_s4_ff <= l2_s3_ff;
         n_s4_ff  <= n_s3_ff;
      end
   end

   // stage 5: day within the year, and year base 100 * (n - 49) + i
   always_comb begin
      t_prod = {11'd0, i_ff} * 18'd1461;
      l3_sum = {2'd0, l2_s4_ff} + 18'd31 - {2'd0, t_prod[17:2]};
      l3_in  = l3_sum[8:0];
      yb_in  = ({8'd0, n_s4_ff} * 16'd100) - 16'd4900 + {9'd0, i_ff};
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         l3_s5_ff <= l3_in;
         yb_s5_ff <= yb_in;
      end
   end

   // stage 6: march based month
   always_comb begin
      j_prod = {23'd0, l3_s5_ff} * {9'd0, MON_MULT};
      j_in   = j_prod[MON_SHIFT +: 4];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         j_s6_ff  <= j_in;
         l3_s6_ff <= l3_s5_ff;
         yb_s6_ff <= yb_s5_ff;
      end
   end

   // stage 7: day of month
   always_comb begin
      k_prod = {27'd0, j_s6_ff} * {4'd0, DOM_MULT};
      k_diff = l3_s6_ff - k_prod[DOM_SHIFT +: 9];
      day_in = k_diff[DAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         day_s7_ff <= day_in;
         j_s7_ff   <= j_s6_ff;
         yb_s7_ff  <= yb_s6_ff;
      end
   end

   // stage 8: fold january and february back into the next year
   always_comb begin
      lq       = (j_s7_ff >= 4'd11);
      mon_in   = j_s7_ff + 4'd2 - (lq ? 4'd12 : 4'd0);
      year_sum = yb_s7_ff + {15'd0, lq};
      year_in  = year_sum[YEAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         mon_ff  <= mon_in;
         day_ff  <= day_s7_ff;
         year_ff <= year_in;
      end
   end

   always_comb begin
      out_res.julian_day   = tag_ff[STAGES-1].jd;
      out_res.new_month    = mon_ff;
      out_res.new_day      = day_ff;
      out_res.new_year     = year_ff;
      out_res.was_invalid  = tag_ff[STAGES-1].bad;
      out_res.out_of_range = tag_ff[STAGES-1].clamp;
   end

endmodule
`default_nettype wire

// ----- sim/gregorian_date_day_shifter_top_tb.sv -----
// testbench for the gregorian date day shifter: random and directed dates checked by a scoreboard
`timescale 1ns / 1ps
module gregorian_date_day_shifter_top_tb;
   import gdds_pkg::*;

   // predicts each shifted date and checks results in arrival order
   class date_shift_scoreboard;
      result_type shifted_dates[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      // days in a month, 4/100/400 leap rule, year 0 is leap
      static function int month_length(input int m, input int y);
         bit leap;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         case (m)
            MONTH_FEB: begin
               return leap ? 29 : 28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      function result_type shift_date(input logic [MONTH_W-1:0] month,
                                      input logic [DAY_W-1:0] day,
                                      input logic [YEAR_W-1:0] year,
                                      input logic signed [OFFSET_W-1:0] offset);
         longint m, d, y, a, jd, sh, l, n, i, j, k;
         longint jd_lo, jd_hi;
         result_type r;
         m = longint'(month);
         d = longint'(day);
         y = longint'(year);
         jd_lo = longint'(JD_MIN);
         jd_hi = longint'(JD_MAX);
         r.was_invalid = (y > YEAR_MAX) || (m < MONTH_JAN) || (m > MONTH_DEC) ||
                         (d < 1) || (d > month_length(int'(m), int'(y)));
         if (r.was_invalid) begin
            m = DEF_MONTH;
            d = DEF_DAY;
            y = DEF_YEAR;
         end
         // forward conversion, divisions truncate toward zero
         a = (m - 14) / 12;
         jd = d - 32075 + 1461 * (y + 4800 + a) / 4
              + 367 * (m - 2 - a * 12) / 12
              - 3 * ((y + 4900 + a) / 100) / 4;
         sh = jd + offset;
         r.out_of_range = (sh < jd_lo) || (sh > jd_hi);
         if (sh < jd_lo) begin
            sh = jd_lo;
         end else if (sh > jd_hi) begin
            sh = jd_hi;
         end
         // inverse conversion
         l = sh + 68569;
         n = 4 * l / 146097;
         l = l - (146097 * n + 3) / 4;
         i = 4000 * (l + 1) / 1461001;
         l = l - 1461 * i / 4 + 31;
         j = 80 * l / 2447;
         k = l - 2447 * j / 80;
         l = j / 11;
         j = j + 2 - 12 * l;
         i = 100 * (n - 49) + i + l;
         r.julian_day = jd[JD_W-1:0];
         r.new_month = j[MONTH_W-1:0];
         r.new_day = k[DAY_W-1:0];
         r.new_year = i[YEAR_W-1:0];
         return r;
      endfunction

      function void note_request(input logic [MONTH_W-1:0] month,
                                 input logic [DAY_W-1:0] day,
                                 input logic [YEAR_W-1:0] year,
                                 input logic signed [OFFSET_W-1:0] offset);
         shifted_dates.push_back(shift_date(month, day, year, offset));
      endfunction

      function void compare_field(input string field, input longint want,
                                  input longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_response(input result_type got);
         result_type want;
         if (shifted_dates.size() == 0) begin
            $display("%0t: result with none pending, expected nothing, actual %p",
                     $time, got);
            failures++;
            return;
         end
         want = shifted_dates.pop_front();
         compare_field("julian_day", want.julian_day, got.julian_day);
         compare_field("new_month", want.new_month, got.new_month);
         compare_field("new_day", want.new_day, got.new_day);
         compare_field("new_year", want.new_year, got.new_year);
         compare_field("was_invalid", want.was_invalid, got.was_invalid);
         compare_field("out_of_range", want.out_of_range, got.out_of_range);
      endfunction

      function int pending();
         return shifted_dates.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [MONTH_W-1:0]         req_month_in;
   logic [DAY_W-1:0]           req_day_in;
   logic [YEAR_W-1:0]          req_year_in;
   logic signed [OFFSET_W-1:0] req_offset_days;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [JD_W-1:0]            rsp_julian_day;
   logic [MONTH_W-1:0]         rsp_new_month;
   logic [DAY_W-1:0]           rsp_new_day;
   logic [YEAR_W-1:0]          rsp_new_year;
   logic                       rsp_was_invalid;
   logic                       rsp_out_of_range;

   // set during a window of the random part: both sides run without gaps
   bit steady_run = 1'b0;

   date_shift_scoreboard board = new();

   gregorian_date_day_shifter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_year_in      (req_year_in),
      .req_offset_days  (req_offset_days),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_julian_day   (rsp_julian_day),
      .rsp_new_month    (rsp_new_month),
      .rsp_new_day      (rsp_new_day),
      .rsp_new_year     (rsp_new_year),
      .rsp_was_invalid  (rsp_was_invalid),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one date item: random gap, then hold valid until the block takes it
   task automatic submit_date(input logic [MONTH_W-1:0] month,
                              input logic [DAY_W-1:0] day,
                              input logic [YEAR_W-1:0] year,
                              input logic signed [OFFSET_W-1:0] offset);
      // about a third of the cycles idle, valid low
      while (!steady_run && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_month_in    <= month;
      req_day_in      <= day;
      req_year_in     <= year;
      req_offset_days <= offset;
      // values read here are the ones seen at the edge
      do begin
         @(posedge clock);
      end while (!req_ready);
      board.note_request(month, day, year, offset);
   endtask

   // result side: check on handshake, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response({rsp_julian_day, rsp_new_month, rsp_new_day,
                               rsp_new_year, rsp_was_invalid, rsp_out_of_range});
      end
      rsp_ready <= steady_run || ($urandom_range(99) >= 34);
   end

   initial begin
      int pick;
      int shift;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      logic [YEAR_W-1:0]  y;

      // every input known from time zero
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_month_in    <= '0;
      req_day_in      <= '0;
      req_year_in     <= '0;
      req_offset_days <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: span ends, clamps, leap rule, bad fields
      submit_date(MONTH_JAN, 5'd1, 14'd0, 24'sd0);           // first day of the span
      submit_date(MONTH_DEC, 5'd31, 14'd9999, 24'sd0);       // last day of the span
      submit_date(MONTH_JAN, 5'd1, 14'd0, -24'sd1);          // clamp below year 0
      submit_date(MONTH_DEC, 5'd31, 14'd9999, 24'sd1);       // clamp past year 9999
      submit_date(MONTH_FEB, 5'd29, 14'd0, 24'sd0);          // year 0 is leap
      submit_date(MONTH_FEB, 5'd29, 14'd1900, 24'sd0);       // century, not leap
      submit_date(MONTH_FEB, 5'd29, 14'd2000, 24'sd0);       // 400 year leap
      submit_date(MONTH_FEB, 5'd29, 14'd2001, 24'sd0);       // plain non-leap
      submit_date(MONTH_FEB, 5'd29, 14'd2004, 24'sd365);     // plain leap
      submit_date(4'd0, 5'd10, 14'd2020, 24'sd0);            // month zero
      submit_date(4'd15, 5'd31, 14'd16383, -24'sd8388608);   // all fields at top, most negative
      submit_date(4'd13, 5'd1, 14'd2000, 24'sd0);            // month past december
      submit_date(MONTH_JUN, 5'd0, 14'd2000, 24'sd0);        // day zero
      submit_date(MONTH_APR, 5'd31, 14'd2000, 24'sd0);       // past the month end
      submit_date(MONTH_JUN, 5'd30, 14'd2000, 24'sd0);       // month end, fine
      submit_date(MONTH_JAN, 5'd31, 14'd10000, 24'sd0);      // year above 9999
      submit_date(MONTH_JUL, 5'd4, 14'd16383, 24'sd0);       // top year code
      submit_date(MONTH_MAY, 5'd11, 14'd1959, 24'sd8388607); // largest positive offset
      submit_date(MONTH_MAR, 5'd1, 14'd2000, -24'sd1);       // back onto february 29
      submit_date(MONTH_JAN, 5'd1, 14'd1, -24'sd366);        // exactly the low end
      submit_date(MONTH_DEC, 5'd31, 14'd9998, 24'sd365);     // exactly the high end
      submit_date(MONTH_JAN, 5'd1, 14'd0, -24'sd5373484);    // deep below the span
      submit_date(MONTH_DEC, 5'd31, 14'd9999, -24'sd3652424);// whole span backwards
      submit_date(MONTH_OCT, 5'd15, 14'd1582, 24'sd0);
      submit_date(MONTH_NOV, 5'd30, 14'd2023, 24'sd0);

      // random: mostly good dates, some near the span ends, some noise, some month ends
      for (int idx = 0; idx < 1050; idx++) begin
         steady_run = (idx >= 400) && (idx < 600);
         pick = $urandom_range(99);
         if (pick < 70) begin
            // good date with small, medium or span-wide offset
            m = MONTH_W'($urandom_range(12, 1));
            y = YEAR_W'($urandom_range(9999, 0));
            d = DAY_W'($urandom_range(
                   date_shift_scoreboard::month_length(int'(m), int'(y)), 1));
            case ($urandom_range(9))
               0, 1: shift = int'($urandom_range(80)) - 40;
               2, 3, 4: shift = int'($urandom_range(2 * 5373484)) - 5373484;
               default: shift = int'($urandom_range(80000)) - 40000;
            endcase
         end else if (pick < 80) begin
            // close to year 0 or year 9999, offsets that may cross
            d = DAY_W'($urandom_range(31, 1));
            if ($urandom_range(1)) begin
               m = MONTH_JAN;
               y = YEAR_W'($urandom_range(1, 0));
            end else begin
               m = MONTH_DEC;
               y = YEAR_W'($urandom_range(9999, 9998));
            end
            shift = int'($urandom_range(1600)) - 800;
         end else if (pick < 90) begin
            // raw bits in every field
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
            y = YEAR_W'($urandom);
            shift = $urandom;
         end else begin
            // month end probing, century years for the leap rule
            m = $urandom_range(1) ? MONTH_FEB : MONTH_W'($urandom_range(12, 1));
            y = $urandom_range(1) ? YEAR_W'($urandom_range(9999))
                                  : YEAR_W'(100 * $urandom_range(99));
            d = DAY_W'($urandom_range(31, 28));
            shift = int'($urandom_range(800)) - 400;
         end
         submit_date(m, d, y, shift[OFFSET_W-1:0]);
      end
      steady_run = 1'b0;
      req_valid <= 1'b0;

      // drain, then a margin past the pipeline depth for strays
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
      if (board.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // timeout, far beyond the slowest correct run
   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/gdds_pkg.sv
sv/gdds_to_jd.sv
sv/gdds_from_jd.sv
sv/gregorian_date_day_shifter_top.sv
sim/gregorian_date_day_shifter_top_tb.sv
